### sv/mwc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lag-3 multiply-with-carry generator: shared definitions
// Operation codes, state word indexes and the fixed multipliers and offsets
// of the generator, the mixer and the seeding LCG.
// ----------------------------------------------------------------------------
package mwc_pkg;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_RESEED = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    IDX_OLDEST = 2'd0,
    IDX_MIDDLE = 2'd1,
    IDX_NEWEST = 2'd2,
    IDX_CARRY  = 2'd3
  } word_index_e;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned PROD_W     = 2 * WORD_W;
  localparam int unsigned WARMUP_DEF = 13;

  localparam logic [WORD_W-1:0] MWC_MUL  = 32'd4293666429;
  localparam logic [WORD_W-1:0] MIX_HI   = 32'd4078645709;
  localparam logic [WORD_W-1:0] MIX_LO   = 32'd3580663381;
  localparam logic [WORD_W-1:0] SEED_MUL = 32'd3571494541;
  localparam logic [WORD_W-1:0] SEED_ADD = 32'd3753453877;

  localparam int unsigned SEED_VALS  = 5;
  localparam logic [5:0]  SEED_GUARD = 6'd63;

endpackage
`default_nettype wire

### sv/mwc_lag3_mixed_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lag-3 multiply-with-carry random generator with mixed 64-bit output
// Sequencer around one shared 32x32 multiplier: draws, reseeding with
// warm-up, and single state word writes and reads.
// ----------------------------------------------------------------------------
//   Channel   Handshake               Word
//   command   start / busy            opcode_i, data_value_i, word_index_i
//   result    result_valid_o strobe   random_value_o, state_word_o
//
// A draw runs through S_DRAW_UPD, S_MIX_HI, S_MIX_LO and S_MIX_SUM before the
// next command can be accepted; it uses three registered products on the
// shared multiplier. State writes and reads leave the block idle; their result
// word comes in the cycle after acceptance. A reseed runs S_LCG_ADD, S_LCG_MUL,
// S_LCG_ACC per LCG step (at least 5 steps), then 13 warm-up draws by default.
// After reset the block seeds itself with zero in the same way, busy high,
// and gives no result for it. The receiver cannot stall: a result word is on
// the result ports for exactly one cycle.
// ----------------------------------------------------------------------------
module mwc_lag3_mixed_random_generator #(
  parameter int unsigned WarmupDraws = mwc_pkg::WARMUP_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [31:0] data_value_i,
  input  wire logic [1:0]  word_index_i,
  output logic             result_valid_o,
  output logic [63:0]      random_value_o,
  output logic [31:0]      state_word_o
);

  localparam int unsigned WarmW = (WarmupDraws > 0) ? $clog2(WarmupDraws + 1) : 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DRAW_UPD,
    S_MIX_HI,
    S_MIX_LO,
    S_MIX_SUM,
    S_LCG_ADD,
    S_LCG_MUL,
    S_LCG_ACC,
    S_WARM_MUL,
    S_WARM_UPD
  } state_e;

  state_e       state_q;
  logic [31:0]  oldest_q, middle_q, newest_q, carry_q;
  logic [31:0]  seed_q, lcg_q;
  logic [2:0]   prog_q;
  logic [5:0]   guard_q;
  logic [WarmW-1:0] warm_q;
  logic         reply_q;
  logic         valid_q;
  logic [63:0]  random_q;
  logic [31:0]  word_q;

  logic [63:0]  p1_q;
  logic [31:0]  sum_q;

  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod;
  logic [63:0]  x_d;
  logic [31:0]  lcg_d;
  logic         accept;
  logic         seed_done;

  mwc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  always_comb begin
    mul_a = oldest_q;
    mul_b = mwc_pkg::MWC_MUL;
    unique case (state_q)
      S_MIX_HI: begin
        mul_a = carry_q;
        mul_b = mwc_pkg::MIX_HI;
      end
      S_MIX_LO: begin
        mul_a = newest_q;
        mul_b = mwc_pkg::MIX_LO;
      end
      S_LCG_MUL: begin
        mul_a = sum_q;
        mul_b = mwc_pkg::SEED_MUL;
      end
      default: begin
        mul_a = oldest_q;
        mul_b = mwc_pkg::MWC_MUL;
      end
    endcase
  end

  assign accept    = start && (state_q == S_IDLE);
  assign busy      = (state_q != S_IDLE);
  assign x_d       = prod + {32'd0, carry_q};
  assign lcg_d     = prod[31:0] + mwc_pkg::SEED_ADD;
  assign seed_done = ((lcg_d[30:0] != 31'd0) && (prog_q == 3'(mwc_pkg::SEED_VALS - 1)))
                     || (guard_q == mwc_pkg::SEED_GUARD);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MIX_LO) begin
      p1_q <= prod;
    end
    if (state_q == S_LCG_ADD) begin
      sum_q <= lcg_q + seed_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LCG_ADD;
      oldest_q <= '0;
      middle_q <= '0;
      newest_q <= '0;
      carry_q  <= '0;
      seed_q   <= '0;
      lcg_q    <= mwc_pkg::SEED_ADD;
      prog_q   <= '0;
      guard_q  <= '0;
      warm_q   <= '0;
      reply_q  <= 1'b0;
      valid_q  <= 1'b0;
      random_q <= '0;
      word_q   <= '0;
    end else begin
      valid_q  <= 1'b0;
      random_q <= '0;
      word_q   <= '0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (mwc_pkg::opcode_e'(opcode_i))
              mwc_pkg::OP_DRAW: begin
                state_q <= S_DRAW_UPD;
              end
              mwc_pkg::OP_RESEED: begin
                seed_q   <= data_value_i;
                lcg_q    <= mwc_pkg::SEED_ADD;
                prog_q   <= '0;
                guard_q  <= '0;
                oldest_q <= '0;
                middle_q <= '0;
                newest_q <= '0;
                carry_q  <= '0;
                reply_q  <= 1'b1;
                state_q  <= S_LCG_ADD;
              end
              mwc_pkg::OP_WRITE: begin
                valid_q <= 1'b1;
                unique case (mwc_pkg::word_index_e'(word_index_i))
                  mwc_pkg::IDX_OLDEST: oldest_q <= data_value_i;
                  mwc_pkg::IDX_MIDDLE: middle_q <= data_value_i;
                  mwc_pkg::IDX_NEWEST: newest_q <= data_value_i;
                  mwc_pkg::IDX_CARRY:  carry_q  <= data_value_i;
                  default:             carry_q  <= data_value_i;
                endcase
              end
              mwc_pkg::OP_READ: begin
                valid_q <= 1'b1;
                unique case (mwc_pkg::word_index_e'(word_index_i))
                  mwc_pkg::IDX_OLDEST: word_q <= oldest_q;
                  mwc_pkg::IDX_MIDDLE: word_q <= middle_q;
                  mwc_pkg::IDX_NEWEST: word_q <= newest_q;
                  mwc_pkg::IDX_CARRY:  word_q <= carry_q;
                  default:             word_q <= carry_q;
                endcase
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_DRAW_UPD, S_WARM_UPD: begin
          oldest_q <= middle_q;
          middle_q <= newest_q;
          newest_q <= x_d[31:0];
          carry_q  <= x_d[63:32];
          if (state_q == S_DRAW_UPD) begin
            state_q <= S_MIX_HI;
          end else if (warm_q == WarmW'(1)) begin
            valid_q <= reply_q;
            state_q <= S_IDLE;
          end else begin
            warm_q  <= warm_q - WarmW'(1);
            state_q <= S_WARM_MUL;
          end
        end
        S_MIX_HI: begin
          state_q <= S_MIX_LO;
        end
        S_MIX_LO: begin
          state_q <= S_MIX_SUM;
        end
        S_MIX_SUM: begin
          random_q <= p1_q + {prod[31:0], prod[63:32]};
          valid_q  <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_LCG_ADD: begin
          state_q <= S_LCG_MUL;
        end
        S_LCG_MUL: begin
          state_q <= S_LCG_ACC;
        end
        S_LCG_ACC: begin
          lcg_q   <= lcg_d;
          guard_q <= guard_q + 6'd1;
          if (lcg_d[30:0] != 31'd0) begin
            case (prog_q)
              3'd1:    carry_q  <= {1'b0, lcg_d[30:0]};
              3'd2:    newest_q <= {1'b0, lcg_d[30:0]};
              3'd3:    middle_q <= {1'b0, lcg_d[30:0]};
              3'd4:    oldest_q <= {1'b0, lcg_d[30:0]};
              default: ;
            endcase
          end
          if (seed_done) begin
            prog_q <= '0;
            if (WarmupDraws == 0) begin
              valid_q <= reply_q;
              state_q <= S_IDLE;
            end else begin
              warm_q  <= WarmW'(WarmupDraws);
              state_q <= S_WARM_MUL;
            end
          end else begin
            if (lcg_d[30:0] != 31'd0) begin
              prog_q <= prog_q + 3'd1;
            end
            state_q <= S_LCG_ADD;
          end
        end
        S_WARM_MUL: begin
          state_q <= S_WARM_UPD;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign random_value_o = random_q;
  assign state_word_o   = word_q;

  a_valid_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word shown while busy");

  a_one_field_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (random_value_o == 64'd0 || state_word_o == 32'd0))
    else $error("both result fields nonzero");

  a_access_replies: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (opcode_i == mwc_pkg::OP_WRITE || opcode_i == mwc_pkg::OP_READ))
    |=> (result_valid_o && !busy))
    else $error("state access gave no result word");

  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == mwc_pkg::OP_DRAW) |=> (busy && !result_valid_o))
    else $error("draw did not hold the block busy");

endmodule
`default_nettype wire

### sv/mwc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared 32x32 multiplier
// Unsigned full-width product, registered; the product of the operands
// presented in one cycle is available in the next.
// ----------------------------------------------------------------------------
module mwc_mul (
  input  wire logic                        clk_i,
  input  wire logic [mwc_pkg::WORD_W-1:0]  a_i,
  input  wire logic [mwc_pkg::WORD_W-1:0]  b_i,
  output logic      [mwc_pkg::PROD_W-1:0]  p_o
);

  logic [mwc_pkg::PROD_W-1:0] p_q;
  logic [mwc_pkg::PROD_W-1:0] p_d;

  assign p_d = mwc_pkg::PROD_W'(a_i) * mwc_pkg::PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire
